[src/nbdc_pkg.sv]
`default_nettype none

package nbdc_pkg;

    localparam int FEAT_IDX_W = 8;
    localparam int LEVEL_W    = 3;
    localparam int LABEL_W    = 4;
    localparam int CLASS_W    = 4;
    localparam int OUT_SCORE_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int LOG_W      = 18;
    localparam int LOG_STEPS  = 9;

    localparam logic ACT_TRAIN    = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PENALTY   = 1'd1;

    typedef struct packed {
        logic                  action;
        logic [FEAT_IDX_W-1:0] feature_index;
        logic [LEVEL_W-1:0]    feature_value;
        logic [LABEL_W-1:0]    class_label;
        logic                  last_feature;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_W-1:0]            predicted_class;
        logic signed [OUT_SCORE_W-1:0] best_score;
        logic                          label_matches;
    } out_item_t;

endpackage

`default_nettype wire

[src/naive_bayes_discrete_classifier_core.sv]
// categorical naive bayes classifier core
// s_ channel: one feature of a sample per transfer (action, index, level, label,
// last flag). action 0 trains: counts for (label, feature, level) go up, and on
// the last feature the class count and total go up as well. action 1 classifies:
// every class score takes log(feature count) - log(class count); on the last
// feature the prior term is added, the argmax over classes_in_use is formed and
// one transfer leaves on the m_ channel. cfg_ channel writes the two registers
// and is always ready; write it only while the core is idle.
// feature counts live in one single-port-read, single-port-write ram with a
// registered read, accessed read-modify-write, one item at a time.
// train item: a touched feature count is read, then written back incremented.
// classify item: per class a ram read, two log evaluations on one shared
// squaring unit (one when the feature cell is out of range), two score updates;
// the last feature adds a log(total) evaluation, a pass over the classes in use
// for the argmax and a load of the output register.
// reset: registers take their reset values, then a clearing pass zeroes the ram,
// one entry per cycle (NUM_CLASSES*NUM_FEATURES*NUM_LEVELS entries, 9600 by
// default), with s_ready low. a result waits in the output register while
// m_ready is low; a further result waits in the core until it is taken.
`default_nettype none

module naive_bayes_discrete_classifier_core #(
    parameter int NUM_CLASSES  = 10,
    parameter int NUM_FEATURES = 192,
    parameter int NUM_LEVELS   = 5,
    parameter int COUNT_BITS   = 13,
    parameter int SCORE_BITS   = 24
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  nbdc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output nbdc_pkg::out_item_t              m_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [nbdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [nbdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nbdc_pkg::*;

    localparam int DEPTH   = NUM_CLASSES * NUM_FEATURES * NUM_LEVELS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int SUM_W   = SCORE_BITS + 4;
    localparam int WIDE_W  = ADDR_W + 12;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [SUM_W-1:0] SCORE_HI = SUM_W'((64'sd1 <<< (SCORE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SCORE_LO = -SCORE_HI - SUM_W'(1);

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_TR_RD = 12'b0000_0000_0100,
        ST_LT    = 12'b0000_0000_1000,
        ST_RD    = 12'b0000_0001_0000,
        ST_RDW   = 12'b0000_0010_0000,
        ST_LF    = 12'b0000_0100_0000,
        ST_LC    = 12'b0000_1000_0000,
        ST_UPD1  = 12'b0001_0000_0000,
        ST_UPD2  = 12'b0010_0000_0000,
        ST_MAX   = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    logic [ADDR_W-1:0]     clr_reg;
    in_item_t              item_reg;
    logic [ADDR_W-1:0]     wr_addr_reg;
    logic [CLS_W-1:0]      c_reg;
    logic [3:0]            ciu_reg;
    logic [15:0]           pen_reg;
    logic [COUNT_BITS-1:0] cc_reg [NUM_CLASSES];
    logic [COUNT_BITS-1:0] total_reg;
    logic signed [SCORE_BITS-1:0] score_reg [NUM_CLASSES];
    logic signed [LOG_W-1:0] lt_reg, lf_reg, lc_reg;
    logic [CLS_W-1:0]      best_reg;
    logic signed [SCORE_BITS-1:0] best_val_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     mem_addr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;

    logic [31:0]           log_x_reg;
    logic [LOG_STEPS-1:0]  log_f_reg;
    logic [3:0]            log_e_reg;
    logic [3:0]            log_cnt_reg;
    logic                  log_zero_reg;
    logic                  log_start;
    logic [COUNT_BITS-1:0] log_n;
    logic                  log_done;
    logic signed [LOG_W-1:0] log_res;
    logic [3:0]            lead;
    logic [63:0]           log_prod;
    logic [32:0]           log_sq;

    logic                  s_fire;
    logic                  s_cell_ok, s_label_ok, item_cell_ok;
    logic [CLS_W-1:0]      cls_sel;
    in_item_t              addr_item;
    logic [WIDE_W-1:0]     wide_addr;
    logic [CLS_W-1:0]      used_m1;
    logic signed [SCORE_BITS-1:0] score_cur;
    logic                  last_class;

    function automatic logic signed [SCORE_BITS-1:0] sat_add(
        input logic signed [SCORE_BITS-1:0] s,
        input logic signed [LOG_W:0]        d
    );
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(s) + SUM_W'(d);
        if (v > SCORE_HI) begin
            v = SCORE_HI;
        end
        if (v < SCORE_LO) begin
            v = SCORE_LO;
        end
        return v[SCORE_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v != COUNT_MAX) ? v + COUNT_BITS'(1) : v;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign s_cell_ok  = (32'(s_data.feature_index) < NUM_FEATURES)
                        && (32'(s_data.feature_value) < NUM_LEVELS);
    assign s_label_ok = (32'(s_data.class_label) < NUM_CLASSES);
    assign item_cell_ok = (32'(item_reg.feature_index) < NUM_FEATURES)
                          && (32'(item_reg.feature_value) < NUM_LEVELS);

    assign addr_item = (state_reg == ST_IDLE) ? s_data : item_reg;
    assign cls_sel   = (state_reg == ST_IDLE) ? s_data.class_label[CLS_W-1:0] : c_reg;
    assign wide_addr = (WIDE_W'(cls_sel) * WIDE_W'(NUM_FEATURES)
                        + WIDE_W'(addr_item.feature_index)) * WIDE_W'(NUM_LEVELS)
                       + WIDE_W'(addr_item.feature_value);
    assign mem_addr  = wide_addr[ADDR_W-1:0];

    assign score_cur  = score_reg[c_reg];
    assign last_class = (32'(c_reg) == NUM_CLASSES - 1);

    always_comb begin
        if (ciu_reg == 4'd0) begin
            used_m1 = '0;
        end else if (32'(ciu_reg) > NUM_CLASSES) begin
            used_m1 = CLS_W'(NUM_CLASSES - 1);
        end else begin
            used_m1 = CLS_W'(ciu_reg - 4'd1);
        end
    end

    // shared log unit: normalize then nine squarings
    always_comb begin
        lead = '0;
        for (int i = 0; i < COUNT_BITS; i++) begin
            if (log_n[i]) begin
                lead = 4'(i);
            end
        end
    end

    assign log_prod = 64'(log_x_reg) * 64'(log_x_reg);
    assign log_sq   = log_prod[63:31];
    assign log_done = (log_cnt_reg == 4'(LOG_STEPS));
    assign log_res  = log_zero_reg ? -LOG_W'(signed'({1'b0, pen_reg}))
                      : LOG_W'({log_e_reg, 8'd0}) + LOG_W'(log_f_reg[LOG_STEPS-1:1])
                        + LOG_W'(log_f_reg[0]);

    always_comb begin
        log_start = 1'b0;
        log_n     = total_reg;
        unique case (state_reg)
            ST_IDLE: begin
                log_start = s_fire && (s_data.action == ACT_CLASSIFY) && s_data.last_feature;
                log_n     = total_reg;
            end
            ST_RDW: begin
                log_start = 1'b1;
                log_n     = item_cell_ok ? rd_data_reg : cc_reg[c_reg];
            end
            ST_LF: begin
                log_start = log_done;
                log_n     = cc_reg[c_reg];
            end
            default: begin
                log_start = 1'b0;
                log_n     = total_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_cnt_reg <= 4'(LOG_STEPS);
        end else if (log_start) begin
            log_cnt_reg <= '0;
        end else if (!log_done) begin
            log_cnt_reg <= log_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (log_start) begin
            log_x_reg    <= 32'(log_n) << (5'd31 - 5'(lead));
            log_f_reg    <= '0;
            log_e_reg    <= lead;
            log_zero_reg <= (log_n == '0);
        end else if (!log_done) begin
            if (log_sq[32]) begin
                log_x_reg <= log_sq[32:1];
                log_f_reg <= {log_f_reg[LOG_STEPS-2:0], 1'b1};
            end else begin
                log_x_reg <= log_sq[31:0];
                log_f_reg <= {log_f_reg[LOG_STEPS-2:0], 1'b0};
            end
        end
    end

    // count ram
    always_comb begin
        mem_we = 1'b0;
        mem_wa = wr_addr_reg;
        mem_wd = bump(rd_data_reg);
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end else if (state_reg == ST_TR_RD) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_addr];
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ciu_reg <= 4'd10;
            pen_reg <= 16'd4096;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CLASSES_IN_USE: ciu_reg <= cfg_data[3:0];
                CFG_ZERO_PENALTY:   pen_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            c_reg       <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                cc_reg[i]    <= '0;
                score_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (32'(clr_reg) == DEPTH - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        item_reg    <= s_data;
                        wr_addr_reg <= mem_addr;
                        c_reg       <= '0;
                        if (s_data.action == ACT_TRAIN) begin
                            if (s_label_ok) begin
                                if (s_data.last_feature) begin
                                    cc_reg[s_data.class_label[CLS_W-1:0]] <=
                                        bump(cc_reg[s_data.class_label[CLS_W-1:0]]);
                                    total_reg <= bump(total_reg);
                                end
                                if (s_cell_ok) begin
                                    state_reg <= ST_TR_RD;
                                end
                            end
                        end else if (s_data.last_feature) begin
                            state_reg <= ST_LT;
                        end else begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_TR_RD: state_reg <= ST_IDLE;
                ST_LT: begin
                    if (log_done) begin
                        lt_reg    <= log_res;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: state_reg <= ST_RDW;
                ST_RDW: state_reg <= item_cell_ok ? ST_LF : ST_LC;
                ST_LF: begin
                    if (log_done) begin
                        lf_reg    <= log_res;
                        state_reg <= ST_LC;
                    end
                end
                ST_LC: begin
                    if (log_done) begin
                        lc_reg    <= log_res;
                        state_reg <= ST_UPD1;
                    end
                end
                ST_UPD1: begin
                    if (item_cell_ok) begin
                        score_reg[c_reg] <= sat_add(score_cur, (LOG_W+1)'(lf_reg)
                                                    - (LOG_W+1)'(lc_reg));
                    end
                    state_reg <= ST_UPD2;
                end
                ST_UPD2: begin
                    if (item_reg.last_feature) begin
                        score_reg[c_reg] <= sat_add(score_cur, (LOG_W+1)'(lc_reg)
                                                    - (LOG_W+1)'(lt_reg));
                    end
                    if (last_class) begin
                        c_reg     <= '0;
                        state_reg <= item_reg.last_feature ? ST_MAX : ST_IDLE;
                    end else begin
                        c_reg     <= c_reg + CLS_W'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_MAX: begin
                    if (c_reg == '0 || score_cur > best_val_reg) begin
                        best_reg     <= c_reg;
                        best_val_reg <= score_cur;
                    end
                    if (c_reg == used_m1) begin
                        state_reg <= ST_OUT;
                    end else begin
                        c_reg <= c_reg + CLS_W'(1);
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.predicted_class <= CLASS_W'(best_reg);
                        m_data_reg.best_score <= OUT_SCORE_W'(32'(best_val_reg));
                        m_data_reg.label_matches <=
                            (LABEL_W'(best_reg) == item_reg.class_label);
                        for (int i = 0; i < NUM_CLASSES; i++) begin
                            score_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside output load");
    a_out_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result overwritten while stalled");
    a_log_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        log_cnt_reg <= 4'(LOG_STEPS))
        else $error("log step counter out of range");
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("input taken during ram clear");
`endif

endmodule

`default_nettype wire

[tb/sv/nbdc_checker.sv]
`timescale 1ns / 1ps

module nbdc_checker
    import nbdc_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    input  wire        s_ready,
    input  in_item_t   s_data,
    input  wire        m_valid,
    input  wire        m_ready,
    input  out_item_t  m_data,
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_data,
    output int         fail_count,
    output int         pending
);

    localparam int N_CLS   = 10;
    localparam int N_FEAT  = 192;
    localparam int N_LVL   = 5;
    localparam int CNT_MAX = 8191;
    localparam longint SC_HI = 64'sd8388607;
    localparam longint SC_LO = -64'sd8388608;

    logic [12:0] feat_cnt [0:N_CLS*N_FEAT*N_LVL-1];
    logic [12:0] cls_cnt [0:N_CLS-1];
    logic [12:0] tot_cnt;
    longint      score [0:N_CLS-1];
    logic [3:0]  cls_used;
    logic [15:0] zero_pen;
    out_item_t   predictions [$];

    function automatic longint log_fix(input logic [12:0] n);
        int          e;
        logic [63:0] x;
        logic [8:0]  f;
        if (n == 0) return -longint'(zero_pen);
        e = 0;
        while (e < 12 && (n >> (e + 1)) != 0) e++;
        x = 64'(n) << (31 - e);
        f = '0;
        for (int i = 0; i < LOG_STEPS; i++) begin
            x = (x * x) >> 31;
            f = f << 1;
            if (x >= 64'h1_0000_0000) begin
                f[0] = 1'b1;
                x = x >> 1;
            end
        end
        return longint'(e) * 256 + longint'(f >> 1) + longint'(f[0]);
    endfunction

    function automatic longint sat_add(input longint a, input longint d);
        longint v;
        v = a + d;
        if (v > SC_HI) v = SC_HI;
        if (v < SC_LO) v = SC_LO;
        return v;
    endfunction

    function automatic logic [12:0] bump(input logic [12:0] v);
        return (v < CNT_MAX) ? v + 1'b1 : v;
    endfunction

    task automatic absorb(input in_item_t it);
        bit        ok;
        int        a;
        int        used;
        int        best;
        longint    lc;
        out_item_t r;
        ok = it.feature_index < N_FEAT && it.feature_value < N_LVL;
        if (it.action == ACT_TRAIN) begin
            if (it.class_label < N_CLS) begin
                if (ok) begin
                    a = (it.class_label * N_FEAT + it.feature_index) * N_LVL
                        + it.feature_value;
                    feat_cnt[a] = bump(feat_cnt[a]);
                end
                if (it.last_feature) begin
                    cls_cnt[it.class_label] = bump(cls_cnt[it.class_label]);
                    tot_cnt = bump(tot_cnt);
                end
            end
        end else begin
            for (int c = 0; c < N_CLS; c++) begin
                lc = log_fix(cls_cnt[c]);
                if (ok) begin
                    a = (c * N_FEAT + it.feature_index) * N_LVL + it.feature_value;
                    score[c] = sat_add(score[c], log_fix(feat_cnt[a]) - lc);
                end
                if (it.last_feature) score[c] = sat_add(score[c], lc - log_fix(tot_cnt));
            end
            if (it.last_feature) begin
                used = int'(cls_used);
                if (used < 1) used = 1;
                if (used > N_CLS) used = N_CLS;
                best = 0;
                for (int c = 1; c < used; c++)
                    if (score[c] > score[best]) best = c;
                r.predicted_class = best[3:0];
                r.best_score = score[best][23:0];
                r.label_matches = (best == it.class_label);
                predictions.push_back(r);
                for (int c = 0; c < N_CLS; c++) score[c] = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        out_item_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < N_CLS*N_FEAT*N_LVL; i++) feat_cnt[i] = '0;
            for (int c = 0; c < N_CLS; c++) begin
                cls_cnt[c] = '0;
                score[c] = 0;
            end
            tot_cnt = '0;
            cls_used = 4'd10;
            zero_pen = 16'd4096;
            predictions.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CLASSES_IN_USE) cls_used = cfg_data[3:0];
                else if (cfg_index == CFG_ZERO_PENALTY) zero_pen = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (predictions.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", m_data);
                end else begin
                    exp_r = predictions.pop_front();
                    if (m_data.predicted_class !== exp_r.predicted_class
                            || m_data.best_score !== exp_r.best_score
                            || m_data.label_matches !== exp_r.label_matches) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected class %0d score %0d match %0d,",
                                      " got class %0d score %0d match %0d"},
                                exp_r.predicted_class, exp_r.best_score,
                                exp_r.label_matches, m_data.predicted_class,
                                m_data.best_score, m_data.label_matches);
                    end
                end
            end
            if (s_valid && s_ready) absorb(s_data);
        end
        pending = predictions.size();
    end

endmodule

[tb/sv/naive_bayes_discrete_classifier_core_test.sv]
`timescale 1ns / 1ps

module naive_bayes_discrete_classifier_core_test;
    import nbdc_pkg::*;

    localparam int WATCHDOG = 60000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count;
    int pending;
    int s_idle_pct;
    int m_idle_pct;
    int quiet_cycles;

    naive_bayes_discrete_classifier_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    nbdc_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_feature(input logic act, input logic [7:0] idx, input logic [2:0] lvl,
                                input logic [3:0] lbl, input logic lst);
        in_item_t it;
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        it.action = act;
        it.feature_index = idx;
        it.feature_value = lvl;
        it.class_label = lbl;
        it.last_feature = lst;
        s_valid <= 1'b1;
        s_data <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_samples(input int count);
        int n;
        int len;
        logic act;
        logic [3:0] lbl;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(1, 4);
                act = ($urandom_range(99) < 55) ? ACT_TRAIN : ACT_CLASSIFY;
                lbl = 4'($urandom_range(9));
                for (int i = 0; i < len; i++) begin
                    if (act == ACT_CLASSIFY && $urandom_range(99) < 5)
                        send_feature(ACT_TRAIN, 8'($urandom_range(15)),
                                     3'($urandom_range(4)), 4'($urandom_range(9)), 1'b0);
                    send_feature(act, 8'($urandom_range(15)), 3'($urandom_range(4)), lbl,
                                 i == len - 1);
                    n++;
                end
            end else begin
                send_feature(1'($urandom_range(1)), 8'($urandom_range(255)),
                             3'($urandom_range(7)), 4'($urandom_range(15)),
                             1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_idle_pct = 6;
        m_idle_pct = 84;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners
        send_feature(ACT_CLASSIFY, 8'd0, 3'd0, 4'd0, 1'b1);
        send_feature(ACT_TRAIN, 8'd0, 3'd0, 4'd0, 1'b0);
        send_feature(ACT_TRAIN, 8'd191, 3'd4, 4'd0, 1'b1);
        send_feature(ACT_TRAIN, 8'd191, 3'd4, 4'd9, 1'b1);
        send_feature(ACT_TRAIN, 8'd5, 3'd2, 4'd15, 1'b1);
        send_feature(ACT_TRAIN, 8'd255, 3'd7, 4'd9, 1'b1);
        send_feature(ACT_TRAIN, 8'd192, 3'd5, 4'd3, 1'b1);
        send_feature(ACT_CLASSIFY, 8'd191, 3'd4, 4'd9, 1'b0);
        send_feature(ACT_TRAIN, 8'd0, 3'd0, 4'd9, 1'b0);
        send_feature(ACT_CLASSIFY, 8'd200, 3'd1, 4'd9, 1'b0);
        send_feature(ACT_CLASSIFY, 8'd0, 3'd7, 4'd9, 1'b0);
        send_feature(ACT_CLASSIFY, 8'd0, 3'd0, 4'd9, 1'b1);
        send_feature(ACT_CLASSIFY, 8'd191, 3'd4, 4'd15, 1'b1);
        send_feature(ACT_CLASSIFY, 8'd255, 3'd7, 4'd0, 1'b1);
        settle();
        write_reg(CFG_CLASSES_IN_USE, 16'd0);
        write_reg(CFG_ZERO_PENALTY, 16'd0);
        send_feature(ACT_CLASSIFY, 8'd191, 3'd4, 4'd0, 1'b1);
        send_feature(ACT_CLASSIFY, 8'd7, 3'd3, 4'd1, 1'b1);
        settle();
        write_reg(CFG_CLASSES_IN_USE, 16'd15);
        write_reg(CFG_ZERO_PENALTY, 16'hffff);
        send_feature(ACT_CLASSIFY, 8'd191, 3'd4, 4'd9, 1'b1);
        send_feature(ACT_CLASSIFY, 8'd3, 3'd1, 4'd2, 1'b1);
        settle();

        write_reg(CFG_CLASSES_IN_USE, 16'd10);
        write_reg(CFG_ZERO_PENALTY, 16'd4096);
        random_samples(240);
        settle();

        s_idle_pct = 84;
        m_idle_pct = 6;
        write_reg(CFG_CLASSES_IN_USE, 16'($urandom_range(1, 9)));
        write_reg(CFG_ZERO_PENALTY, 16'($urandom_range(65535)));
        random_samples(240);
        settle();

        s_idle_pct = 0;
        m_idle_pct = 0;
        write_reg(CFG_CLASSES_IN_USE, 16'd1);
        write_reg(CFG_ZERO_PENALTY, 16'd0);
        random_samples(105);
        settle();
        write_reg(CFG_CLASSES_IN_USE, 16'd10);
        write_reg(CFG_ZERO_PENALTY, 16'($urandom_range(65535)));
        random_samples(105);
        settle();

        // drive scores to the negative rail
        write_reg(CFG_ZERO_PENALTY, 16'hffff);
        for (int i = 0; i < 140; i++)
            send_feature(ACT_CLASSIFY, 8'($urandom_range(100, 190)), 3'($urandom_range(4)),
                         4'd4, 1'b0);
        send_feature(ACT_CLASSIFY, 8'd150, 3'd1, 4'd4, 1'b1);
        settle();

        send_feature(ACT_CLASSIFY, 8'd5, 3'd2, 4'd3, 1'b1);
        send_feature(ACT_CLASSIFY, 8'd6, 3'd2, 4'd3, 1'b1);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
